### hdl/kta_pkg.sv
package kta_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam logic [15:0] TTL_DEC = 16'hFFFF;

  typedef enum logic [2:0] {
    OP_SET_VAL  = 3'd0,
    OP_GET_VAL  = 3'd1,
    OP_SET_TTL  = 3'd2,
    OP_GET_TTL  = 3'd3,
    OP_ADD_TTL  = 3'd4,
    OP_AGE      = 3'd5,
    OP_REMOVE   = 3'd6,
    OP_READ     = 3'd7
  } kta_op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_TTL_ZERO  = 2'd3
  } kta_status_e;

  typedef struct packed {
    logic [31:0] id;
    logic [15:0] value;
    logic [15:0] ttl;
  } kta_entry_t;

  typedef struct packed {
    logic              data_we;
    logic              valid_we;
    logic              valid;
    logic [ADDR_W-1:0] addr;
    kta_entry_t        data;
  } kta_wr_t;

  typedef struct packed {
    logic [15:0] ttl;
    logic [15:0] delta;
    logic [31:0] key_a;
    logic [31:0] key_b;
  } kta_alu_req_t;

  typedef struct packed {
    logic [15:0] sum;
    logic        zero;
    logic        eq;
  } kta_alu_rsp_t;

endpackage

### hdl/keyed_table_with_ttl_aging_core.sv
// Channel   Direction  Handshake              Payload
// request   in         in_valid_i/in_stall_o  func, key_id, new_value, ttl_amount, slot_index
// result    out        out_valid_o/out_stall_i status, found_id, found_value, found_ttl,
//                                              slot_valid, occupied
//
// Lookups scan the slots through the single memory read port, one slot a cycle;
// a hit ends the scan early, a miss or an aging tick scans every slot, a slot read needs no scan.
// One shared adder/comparator serves every key compare, ttl add and aging decrement.
// Reset clears all valid bits and the entry count at once; no clearing pass.
// A stalled result waits in the output register; the next request is taken meanwhile.
module keyed_table_with_ttl_aging_core import kta_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         func_i,
  input  logic [31:0]        key_id_i,
  input  logic signed [15:0] new_value_i,
  input  logic signed [15:0] ttl_amount_i,
  input  logic [3:0]         slot_index_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         status_o,
  output logic [31:0]        found_id_o,
  output logic signed [15:0] found_value_o,
  output logic signed [15:0] found_ttl_o,
  output logic               slot_valid_o,
  output logic [4:0]         occupied_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RDSLOT,
    S_DONE
  } state_e;

  state_e                 state_q, state_d;
  kta_op_e                op_q, op_d;
  logic [31:0]            key_q, key_d;
  logic [15:0]            val_q, val_d;
  logic [15:0]            tamt_q, tamt_d;
  logic [ADDR_W-1:0]      sidx_q, sidx_d;
  logic [ADDR_W-1:0]      iss_idx_q, iss_idx_d;
  logic                   iss_q, iss_d;
  logic                   chk_q, chk_d;
  logic [ADDR_W-1:0]      chk_idx_q, chk_idx_d;
  logic                   free_found_q, free_found_d;
  logic [ADDR_W-1:0]      free_idx_q, free_idx_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  kta_status_e            res_status_q, res_status_d;
  logic [31:0]            res_id_q, res_id_d;
  logic [15:0]            res_value_q, res_value_d;
  logic [15:0]            res_ttl_q, res_ttl_d;
  logic                   res_sv_q, res_sv_d;
  logic                   out_valid_q, out_valid_d;
  kta_status_e            out_status_q, out_status_d;
  logic [31:0]            out_id_q, out_id_d;
  logic [15:0]            out_value_q, out_value_d;
  logic [15:0]            out_ttl_q, out_ttl_d;
  logic                   out_sv_q, out_sv_d;
  logic [4:0]             out_occ_q, out_occ_d;

  logic [ADDR_W-1:0]      rd_addr;
  kta_entry_t             rd_data;
  kta_wr_t                wr;
  logic [TABLE_DEPTH-1:0] valid;
  kta_alu_req_t           alu_req;
  kta_alu_rsp_t           alu_rsp;
  logic                   chk_v;
  logic                   chk_last;
  logic                   match;

  kta_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_i      (wr),
    .valid_o   (valid)
  );

  kta_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  assign chk_v    = valid[chk_idx_q];
  assign chk_last = (chk_idx_q == ADDR_W'(TABLE_DEPTH - 1));
  assign match    = chk_v && alu_rsp.eq;

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    key_d        = key_q;
    val_d        = val_q;
    tamt_d       = tamt_q;
    sidx_d       = sidx_q;
    iss_idx_d    = iss_idx_q;
    iss_d        = iss_q;
    chk_d        = chk_q;
    chk_idx_d    = chk_idx_q;
    free_found_d = free_found_q;
    free_idx_d   = free_idx_q;
    cnt_d        = cnt_q;
    res_status_d = res_status_q;
    res_id_d     = res_id_q;
    res_value_d  = res_value_q;
    res_ttl_d    = res_ttl_q;
    res_sv_d     = res_sv_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_id_d     = out_id_q;
    out_value_d  = out_value_q;
    out_ttl_d    = out_ttl_q;
    out_sv_d     = out_sv_q;
    out_occ_d    = out_occ_q;

    wr            = '0;
    wr.data       = rd_data;
    wr.addr       = chk_idx_q;
    rd_addr       = iss_idx_q;
    alu_req.ttl   = rd_data.ttl;
    alu_req.delta = (op_q == OP_AGE) ? TTL_DEC : tamt_q;
    alu_req.key_a = rd_data.id;
    alu_req.key_b = key_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        rd_addr = ADDR_W'(slot_index_i);
        if (in_valid_i) begin
          op_d         = kta_op_e'(func_i);
          key_d        = key_id_i;
          val_d        = new_value_i;
          tamt_d       = ttl_amount_i;
          sidx_d       = ADDR_W'(slot_index_i);
          res_status_d = ST_OK;
          res_id_d     = '0;
          res_value_d  = '0;
          res_ttl_d    = '0;
          res_sv_d     = 1'b0;
          if (kta_op_e'(func_i) == OP_READ) begin
            if (32'(slot_index_i) < 32'(TABLE_DEPTH)) begin
              state_d = S_RDSLOT;
            end else begin
              res_status_d = ST_NOT_FOUND;
              state_d      = S_DONE;
            end
          end else begin
            iss_idx_d    = '0;
            iss_d        = 1'b1;
            chk_d        = 1'b0;
            free_found_d = 1'b0;
            state_d      = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        chk_d     = iss_q;
        chk_idx_d = iss_idx_q;
        if (iss_q) begin
          iss_idx_d = iss_idx_q + ADDR_W'(1);
          iss_d     = (iss_idx_q != ADDR_W'(TABLE_DEPTH - 1));
        end
        if (chk_q) begin
          if (op_q == OP_AGE) begin
            if (chk_v) begin
              wr.data_we  = 1'b1;
              wr.data.ttl = alu_rsp.sum;
              if (alu_rsp.zero) begin
                wr.valid_we = 1'b1;
                wr.valid    = 1'b0;
                cnt_d       = cnt_q - CNT_W'(1);
              end
            end
            if (chk_last) begin
              state_d = S_DONE;
            end
          end else if (match) begin
            state_d = S_DONE;
            iss_d   = 1'b0;
            chk_d   = 1'b0;
            priority case (op_q)
              OP_SET_VAL: begin
                wr.data_we    = 1'b1;
                wr.data.value = val_q;
              end
              OP_GET_VAL: res_value_d = rd_data.value;
              OP_SET_TTL: begin
                wr.data_we  = 1'b1;
                wr.data.ttl = tamt_q;
                res_ttl_d   = tamt_q;
              end
              OP_GET_TTL: res_ttl_d = rd_data.ttl;
              OP_ADD_TTL: begin
                wr.data_we  = 1'b1;
                wr.data.ttl = alu_rsp.sum;
                res_ttl_d   = alu_rsp.sum;
                if (alu_rsp.zero) begin
                  res_status_d = ST_TTL_ZERO;
                end
              end
              default: begin
                wr.valid_we = 1'b1;
                wr.valid    = 1'b0;
                cnt_d       = cnt_q - CNT_W'(1);
              end
            endcase
          end else begin
            if (!chk_v && !free_found_q) begin
              free_found_d = 1'b1;
              free_idx_d   = chk_idx_q;
            end
            if (chk_last) begin
              state_d = S_DONE;
              if (op_q == OP_SET_VAL) begin
                if (free_found_q || !chk_v) begin
                  wr.data_we    = 1'b1;
                  wr.valid_we   = 1'b1;
                  wr.valid      = 1'b1;
                  wr.addr       = free_found_q ? free_idx_q : chk_idx_q;
                  wr.data.id    = key_q;
                  wr.data.value = val_q;
                  wr.data.ttl   = '0;
                  cnt_d         = cnt_q + CNT_W'(1);
                end else begin
                  res_status_d = ST_FULL;
                end
              end else begin
                res_status_d = ST_NOT_FOUND;
              end
            end
          end
        end
      end

      S_RDSLOT: begin
        res_sv_d = valid[sidx_q];
        if (valid[sidx_q]) begin
          res_id_d    = rd_data.id;
          res_value_d = rd_data.value;
        end
        state_d = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_id_d     = res_id_q;
          out_value_d  = res_value_q;
          out_ttl_d    = res_ttl_q;
          out_sv_d     = res_sv_q;
          out_occ_d    = 5'(cnt_q);
          state_d      = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      iss_q       <= 1'b0;
      chk_q       <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      iss_q       <= iss_d;
      chk_q       <= chk_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    key_q        <= key_d;
    val_q        <= val_d;
    tamt_q       <= tamt_d;
    sidx_q       <= sidx_d;
    iss_idx_q    <= iss_idx_d;
    chk_idx_q    <= chk_idx_d;
    free_found_q <= free_found_d;
    free_idx_q   <= free_idx_d;
    res_status_q <= res_status_d;
    res_id_q     <= res_id_d;
    res_value_q  <= res_value_d;
    res_ttl_q    <= res_ttl_d;
    res_sv_q     <= res_sv_d;
    out_status_q <= out_status_d;
    out_id_q     <= out_id_d;
    out_value_q  <= out_value_d;
    out_ttl_q    <= out_ttl_d;
    out_sv_q     <= out_sv_d;
    out_occ_q    <= out_occ_d;
  end

  assign in_stall_o    = (state_q != S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign found_id_o    = out_id_q;
  assign found_value_o = out_value_q;
  assign found_ttl_o   = out_ttl_q;
  assign slot_valid_o  = out_sv_q;
  assign occupied_o    = out_occ_q;

`ifndef NO_ASSERTIONS
  a_count_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) == $countones(valid))
    else $error("entry count out of step with valid bits");

  a_full_means_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_FULL) |-> (occupied_o == 5'(TABLE_DEPTH)))
    else $error("table full reported with free slots");

  a_ttl_zero_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_TTL_ZERO) |-> (found_ttl_o == 16'sd0))
    else $error("ttl zero status with nonzero ttl");
`endif

endmodule

### hdl/kta_store.sv
module kta_store import kta_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [ADDR_W-1:0]      rd_addr_i,
  output kta_entry_t             rd_data_o,
  input  kta_wr_t                wr_i,
  output logic [TABLE_DEPTH-1:0] valid_o
);

  kta_entry_t             mem_q [TABLE_DEPTH];
  kta_entry_t             rd_q;
  logic [TABLE_DEPTH-1:0] valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.data_we) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    rd_q <= mem_q[rd_addr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_i.valid_we) begin
      valid_q[wr_i.addr] <= wr_i.valid;
    end
  end

  assign rd_data_o = rd_q;
  assign valid_o   = valid_q;

endmodule

### hdl/kta_alu.sv
module kta_alu import kta_pkg::*; (
  input  kta_alu_req_t req_i,
  output kta_alu_rsp_t rsp_o
);

  logic [15:0] sum;

  // ttl update wraps modulo 2^16
  assign sum        = req_i.ttl + req_i.delta;
  assign rsp_o.sum  = sum;
  assign rsp_o.zero = (sum == 16'd0);
  assign rsp_o.eq   = (req_i.key_a == req_i.key_b);

endmodule
